### sv/gnms_pkg.sv
package gnms_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_GRAD_BITS = 11;

  localparam int MAG_W     = 11;
  localparam int COORD_W   = 11;
  localparam int DIM_W     = 12;
  localparam int THR_W     = 11;
  localparam int DIR_W     = 2;
  localparam int CLASS_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_DIM   = 2048;
  localparam int TAN_W     = 18;
  localparam int SQ_STEPS  = 4;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // tan(22.5) and tan(67.5) in Q16
  localparam logic [TAN_W-1:0] TAN_LO = 18'd27146;
  localparam logic [TAN_W-1:0] TAN_HI = 18'd158218;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd3;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH    = 12'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT   = 12'd480;
  localparam logic [THR_W-1:0] RST_HIGH_THRESHOLD = 11'd200;
  localparam logic [THR_W-1:0] RST_LOW_THRESHOLD  = 11'd80;

  localparam logic [DIR_W-1:0] DIR_HORZ      = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DIAG_DOWN = 2'd1;
  localparam logic [DIR_W-1:0] DIR_VERT      = 2'd2;
  localparam logic [DIR_W-1:0] DIR_DIAG_UP   = 2'd3;

  localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_WEAK   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_STRONG = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last_col;
    logic               last_row;
  } pos_t;

  typedef struct packed {
    pos_t             pos;
    logic [DIR_W-1:0] dir;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [DIR_W-1:0] dir;
  } pix_t;

  typedef pix_t [2:0][2:0] win_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [MAG_W-1:0]   mag;
    logic [CLASS_W-1:0] cls;
  } result_t;

endpackage

### sv/gnms_if.sv
interface grad_stream_if import gnms_pkg::*; #(parameter int GRAD_BITS = DEF_GRAD_BITS);
  logic                        valid;
  logic                        ready;
  logic signed [GRAD_BITS-1:0] grad_x;
  logic signed [GRAD_BITS-1:0] grad_y;
  modport source (output valid, grad_x, grad_y, input ready);
  modport sink (input valid, grad_x, grad_y, output ready);
endinterface

interface edge_stream_if import gnms_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_col;
  logic [COORD_W-1:0] pixel_row;
  logic [MAG_W-1:0]   thinned_magnitude;
  logic [CLASS_W-1:0] edge_class;
  logic               last_of_run;
  modport source (output valid, pixel_col, pixel_row, thinned_magnitude, edge_class,
                  last_of_run, input ready);
  modport sink (input valid, pixel_col, pixel_row, thinned_magnitude, edge_class,
                last_of_run, output ready);
endinterface

### sv/gnms_sqrt.sv
module gnms_sqrt import gnms_pkg::*; #(
  parameter int GRAD_BITS = DEF_GRAD_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2*GRAD_BITS-1:0]   radicand,
  input  side_t                    in_side,
  output logic                     out_valid,
  output logic [GRAD_BITS-1:0]     root,
  output side_t                    out_side
);

  localparam int G    = GRAD_BITS;
  localparam int NSTG = (G + SQ_STEPS - 1) / SQ_STEPS;

  logic [NSTG-1:0] val_q;
  logic [G+1:0]    rem_q  [NSTG];
  logic [G-1:0]    root_q [NSTG];
  logic [2*G-1:0]  rad_q  [NSTG];
  side_t           side_q [NSTG];

  logic [G+1:0]    rem_next  [NSTG];
  logic [G-1:0]    root_next [NSTG];
  logic [2*G-1:0]  rad_next  [NSTG];

  // two radicand bits per step, SQ_STEPS steps per stage
  always_comb begin
    logic [G+1:0]   cr;
    logic [G+1:0]   rw;
    logic [G+1:0]   tr;
    logic [G-1:0]   ct;
    logic [2*G-1:0] cd;
    for (int k = 0; k < NSTG; k++) begin
      if (k == 0) begin
        cr = '0;
        ct = '0;
        cd = radicand;
      end else begin
        cr = rem_q[k-1];
        ct = root_q[k-1];
        cd = rad_q[k-1];
      end
      for (int t = 0; t < SQ_STEPS; t++) begin
        if (k * SQ_STEPS + t < G) begin
          rw = {cr[G-1:0], cd[2*G-1 -: 2]};
          tr = {ct, 2'b01};
          if (rw >= tr) begin
            cr = rw - tr;
            ct = {ct[G-2:0], 1'b1};
          end else begin
            cr = rw;
            ct = {ct[G-2:0], 1'b0};
          end
          cd = {cd[2*G-3:0], 2'b00};
        end
      end
      rem_next[k]  = cr;
      root_next[k] = ct;
      rad_next[k]  = cd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val_q <= '0;
    end else if (en) begin
      val_q <= {val_q[NSTG-1:0], in_valid} >> 0 == '0 ? '0 : NSTG'({val_q, in_valid});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSTG; k++) begin
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
        rad_q[k]  <= rad_next[k];
        side_q[k] <= (k == 0) ? in_side : side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_valid = val_q[NSTG-1];
  assign root      = root_q[NSTG-1];
  assign out_side  = side_q[NSTG-1];

endmodule

### sv/gnms_window.sv
module gnms_window import gnms_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  pix_t in_pix,
  input  pos_t in_pos,
  output logic out_valid,
  output win_t win,
  output pos_t out_pos
);

  localparam int LIM_W = (MAX_WIDTH < MAX_DIM) ? MAX_WIDTH : MAX_DIM;
  localparam int CAW   = $clog2(LIM_W);
  localparam int DEPTH = 2 * (2 ** CAW);

  // two lines, selected by row parity
  pix_t mem [DEPTH];

  logic [CAW:0] cur_addr;
  logic [CAW:0] prv_addr;

  logic l1_valid;
  pix_t rd_old;
  pix_t rd_prev;
  pix_t l1_pix;
  pos_t l1_pos;

  win_t win_q;
  pos_t pos_q;
  logic valid_q;

  assign cur_addr = {in_pos.row[0], in_pos.col[CAW-1:0]};
  assign prv_addr = {~in_pos.row[0], in_pos.col[CAW-1:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      rd_old  <= mem[cur_addr];
      rd_prev <= mem[prv_addr];
      if (in_valid) begin
        mem[cur_addr] <= in_pix;
      end
      l1_pix <= in_pix;
      l1_pos <= in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (en && l1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= rd_old;
      win_q[1][2] <= rd_prev;
      win_q[2][2] <= l1_pix;
      pos_q       <= l1_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid <= 1'b0;
      valid_q  <= 1'b0;
    end else if (en) begin
      l1_valid <= in_valid;
      valid_q  <= l1_valid;
    end
  end

  assign out_valid = valid_q;
  assign win       = win_q;
  assign out_pos   = pos_q;

endmodule

### sv/gnms_emit.sv
module gnms_emit import gnms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  win_t             win,
  input  pos_t             pos,
  input  logic [THR_W-1:0] high_thr,
  input  logic [THR_W-1:0] low_thr,
  output logic             adv,
  edge_stream_if.source    edge_out
);

  function automatic logic keep_pix(win_t w, int wi, int wj,
                                    logic top, logic bot, logic left, logic right);
    pix_t p;
    int   dy;
    int   dx;
    int   ni;
    int   nj;
    logic k;
    logic ok;
    p = w[wi][wj];
    case (p.dir)
      DIR_HORZ:      begin dy = 0;  dx = 1; end
      DIR_DIAG_DOWN: begin dy = 1;  dx = 1; end
      DIR_VERT:      begin dy = 1;  dx = 0; end
      default:       begin dy = -1; dx = 1; end
    endcase
    k = 1'b1;
    // forward neighbor
    ok = !((dy == 1) && bot) && !((dy == -1) && top) && !((dx == 1) && right);
    ni = wi + dy;
    nj = wj + dx;
    if (ok && ni >= 0 && ni < 3 && nj >= 0 && nj < 3) begin
      if (w[ni][nj].mag > p.mag) k = 1'b0;
    end
    // backward neighbor
    ok = !((dy == 1) && top) && !((dy == -1) && bot) && !((dx == 1) && left);
    ni = wi - dy;
    nj = wj - dx;
    if (ok && ni >= 0 && ni < 3 && nj >= 0 && nj < 3) begin
      if (w[ni][nj].mag > p.mag) k = 1'b0;
    end
    return k;
  endfunction

  logic    rz, r1, cz, c1;
  logic [3:0] keep;
  logic [3:0] mask_n;
  result_t res_n [4];
  result_t res_q [4];
  logic [3:0] pend_q;
  logic [3:0] sel;
  logic [1:0] sel_idx;
  logic       fire;
  logic [COORD_W-1:0] rm1, cm1;

  assign rz  = (pos.row == '0);
  assign r1  = (pos.row == COORD_W'(1));
  assign cz  = (pos.col == '0);
  assign c1  = (pos.col == COORD_W'(1));
  assign rm1 = pos.row - COORD_W'(1);
  assign cm1 = pos.col - COORD_W'(1);

  assign keep[0] = keep_pix(win, 1, 1, r1, 1'b0, c1, 1'b0);
  assign keep[1] = keep_pix(win, 1, 2, r1, 1'b0, cz, 1'b1);
  assign keep[2] = keep_pix(win, 2, 1, rz, 1'b1, c1, 1'b0);
  assign keep[3] = keep_pix(win, 2, 2, rz, 1'b1, cz, 1'b1);

  assign mask_n[0] = !rz && !cz;
  assign mask_n[1] = !rz && pos.last_col;
  assign mask_n[2] = pos.last_row && !cz;
  assign mask_n[3] = pos.last_row && pos.last_col;

  always_comb begin
    pix_t p;
    res_n[0].row = rm1; res_n[0].col = cm1;
    res_n[1].row = rm1; res_n[1].col = pos.col;
    res_n[2].row = pos.row; res_n[2].col = cm1;
    res_n[3].row = pos.row; res_n[3].col = pos.col;
    for (int i = 0; i < 4; i++) begin
      p = win[1 + i / 2][1 + i % 2];
      res_n[i].mag = keep[i] ? p.mag : '0;
      if (!keep[i]) begin
        res_n[i].cls = CLASS_NONE;
      end else if (p.mag >= high_thr) begin
        res_n[i].cls = CLASS_STRONG;
      end else if (p.mag > low_thr) begin
        res_n[i].cls = CLASS_WEAK;
      end else begin
        res_n[i].cls = CLASS_NONE;
      end
    end
  end

  // lowest-index pending result (earliest in raster order) goes first
  assign sel = pend_q & (~pend_q + 4'd1);

  always_comb begin
    if (pend_q[0]) begin
      sel_idx = 2'd0;
    end else if (pend_q[1]) begin
      sel_idx = 2'd1;
    end else if (pend_q[2]) begin
      sel_idx = 2'd2;
    end else begin
      sel_idx = 2'd3;
    end
  end

  assign fire = edge_out.valid && edge_out.ready;
  assign adv  = (pend_q == '0) || (((pend_q & (pend_q - 4'd1)) == '0) && edge_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_q <= '0;
    end else if (adv) begin
      pend_q <= in_valid ? mask_n : '0;
    end else if (fire) begin
      pend_q <= pend_q & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        res_q[i] <= res_n[i];
      end
    end
  end

  assign edge_out.valid             = |pend_q;
  assign edge_out.pixel_col         = res_q[sel_idx].col;
  assign edge_out.pixel_row         = res_q[sel_idx].row;
  assign edge_out.thinned_magnitude = res_q[sel_idx].mag;
  assign edge_out.edge_class        = res_q[sel_idx].cls;
  assign edge_out.last_of_run       = ((pend_q & ~sel) == '0);

endmodule

### sv/gradient_non_maximum_suppression.sv
// Canny-style non-maximum suppression on a raster stream of Sobel gradient
// pairs. One pixel per clock enters while the result side keeps up; it passes
// two front stages for squares and direction, the square-root pipeline at four
// root bits per stage, line-store read, window and result stage. Each pixel is
// reported once the row below it has arrived; the bottom line of a frame gives
// up to four results per input, and the input stalls for the extra results
// since the result stage hands them out one per cycle while the output is
// ready. The line store is 2 x 2^ceil(log2(min(MAX_WIDTH,2048))) entries with one
// write and two reads per cycle. Any register write restarts the frame at (0,0).
module gradient_non_maximum_suppression import gnms_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int GRAD_BITS = DEF_GRAD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  grad_stream_if.sink          grad_in,
  edge_stream_if.source        edge_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int G     = GRAD_BITS;
  localparam int SW    = 2 * GRAD_BITS;
  localparam int PW    = GRAD_BITS + TAN_W;
  localparam int LIM_W = (MAX_WIDTH < MAX_DIM) ? MAX_WIDTH : MAX_DIM;
  localparam int XW    = (GRAD_BITS > MAG_W) ? GRAD_BITS : MAG_W;

  logic [DIM_W-1:0] width_q, height_q;
  logic [THR_W-1:0] high_q, low_q;
  logic [DIM_W-1:0] w_raw, h_raw, eff_w, eff_h;
  logic [COORD_W-1:0] col_q, row_q;
  logic last_col, last_row, accept, adv;

  // front stage
  logic           a_valid;
  logic [G-1:0]   a_gx, a_gy;
  pos_t           a_pos;

  // squares and direction
  logic [G-1:0]   ax, ay;
  logic [SW-1:0]  sum_n;
  logic [PW-1:0]  lhs, p_lo, p_hi;
  logic [DIR_W-1:0] dir_n;
  logic           b_valid;
  logic [SW-1:0]  b_sum;
  side_t          b_side;

  logic           s_valid;
  logic [G-1:0]   s_root;
  side_t          s_side;
  logic [XW-1:0]  root_x;
  pix_t           s_pix;

  logic           w_valid;
  win_t           w_win;
  pos_t           w_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      high_q   <= RST_HIGH_THRESHOLD;
      low_q    <= RST_LOW_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    width_q  <= cfg_data;
        REG_IMAGE_HEIGHT:   height_q <= cfg_data;
        REG_HIGH_THRESHOLD: high_q   <= cfg_data[THR_W-1:0];
        REG_LOW_THRESHOLD:  low_q    <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_raw = (width_q == '0) ? DIM_W'(1) : width_q;
  assign h_raw = (height_q == '0) ? DIM_W'(1) : height_q;
  assign eff_w = (w_raw > DIM_W'(LIM_W)) ? DIM_W'(LIM_W) : w_raw;
  assign eff_h = (h_raw > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : h_raw;

  assign last_col = ({1'b0, col_q} == eff_w - DIM_W'(1));
  assign last_row = ({1'b0, row_q} == eff_h - DIM_W'(1));

  assign grad_in.ready = adv;
  assign accept = grad_in.valid && adv;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + COORD_W'(1);
      end else begin
        col_q <= col_q + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= grad_in.valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_gx           <= grad_in.grad_x;
      a_gy           <= grad_in.grad_y;
      a_pos.col      <= col_q;
      a_pos.row      <= row_q;
      a_pos.last_col <= last_col;
      a_pos.last_row <= last_row;
      b_sum          <= sum_n;
      b_side.pos     <= a_pos;
      b_side.dir     <= dir_n;
    end
  end

  assign ax = a_gx[G-1] ? (~a_gx + G'(1)) : a_gx;
  assign ay = a_gy[G-1] ? (~a_gy + G'(1)) : a_gy;
  assign sum_n = SW'(ax) * SW'(ax) + SW'(ay) * SW'(ay);

  assign lhs  = PW'({ay, 16'b0});
  assign p_lo = PW'(ax) * PW'(TAN_LO);
  assign p_hi = PW'(ax) * PW'(TAN_HI);

  always_comb begin
    if (lhs < p_lo) begin
      dir_n = DIR_HORZ;
    end else if (lhs >= p_hi) begin
      dir_n = DIR_VERT;
    end else if (a_gx[G-1] == a_gy[G-1]) begin
      dir_n = DIR_DIAG_DOWN;
    end else begin
      dir_n = DIR_DIAG_UP;
    end
  end

  gnms_sqrt #(.GRAD_BITS(GRAD_BITS)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b_valid),
    .radicand  (b_sum),
    .in_side   (b_side),
    .out_valid (s_valid),
    .root      (s_root),
    .out_side  (s_side)
  );

  assign root_x    = XW'(s_root);
  assign s_pix.mag = (root_x > XW'(MAG_MAX)) ? MAG_MAX : root_x[MAG_W-1:0];
  assign s_pix.dir = s_side.dir;

  gnms_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_valid),
    .in_pix    (s_pix),
    .in_pos    (s_side.pos),
    .out_valid (w_valid),
    .win       (w_win),
    .out_pos   (w_pos)
  );

  gnms_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (w_valid),
    .win      (w_win),
    .pos      (w_pos),
    .high_thr (high_q),
    .low_thr  (low_q),
    .adv      (adv),
    .edge_out (edge_out)
  );

endmodule

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gnms_pkg::*;

  localparam int GB         = DEF_GRAD_BITS;
  localparam int WD_LIMIT   = 3000;
  localparam int DRAIN_WAIT = 24;
  localparam int RANDOM_N   = 410;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [MAG_W-1:0]   mag;
    logic [CLASS_W-1:0] cls;
    logic               last;
  } edge_pix_t;

  typedef struct {
    int               gx;
    int               gy;
    int               hi;
    int               lo;
    bit               typed;
    logic [MAG_W-1:0] mag;
    logic [CLASS_W-1:0] cls;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;

  grad_stream_if #(.GRAD_BITS(GB)) gin ();
  edge_stream_if eout ();

  gradient_non_maximum_suppression uut (
    .clk(clk),
    .rst(rst),
    .grad_in(gin),
    .edge_out(eout),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  int unsigned width_reg, height_reg, high_thr, low_thr;
  logic [MAG_W-1:0] mag_line [2][MAX_DIM];
  logic [DIR_W-1:0] dir_line [2][MAX_DIM];
  logic [MAG_W-1:0] mag_win [3][3];
  logic [DIR_W-1:0] dir_win [3][3];
  int unsigned col_pos, row_pos;

  edge_pix_t pending_edges[$];
  edge_pix_t last_pred;
  int mismatches;
  int idle_cycles;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned frame_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_DIM) w = MAX_DIM;
    return w;
  endfunction

  function automatic int unsigned frame_height();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > MAX_DIM) h = MAX_DIM;
    return h;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    case (idx)
      REG_IMAGE_WIDTH:    width_reg = val & 12'hfff;
      REG_IMAGE_HEIGHT:   height_reg = val & 12'hfff;
      REG_HIGH_THRESHOLD: high_thr = val & 11'h7ff;
      REG_LOW_THRESHOLD:  low_thr = val & 11'h7ff;
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic int unsigned root_floor(longint unsigned v);
    int unsigned res;
    res = 0;
    for (int b = 11; b >= 0; b--) begin
      if (longint'(res | (1 << b)) * longint'(res | (1 << b)) <= v) res = res | (1 << b);
    end
    return res;
  endfunction

  // classify the window pixel (wi,wj) sitting at image position (pr,pc)
  function automatic void report_pixel(int wi, int wj, int pr, int pc, int w, int h);
    int sx, sy, nr, nc, ni, nj;
    bit keep;
    edge_pix_t e;
    logic [MAG_W-1:0] m;
    m = mag_win[wi][wj];
    case (dir_win[wi][wj])
      DIR_HORZ:      begin sx = 1; sy = 0;  end
      DIR_DIAG_DOWN: begin sx = 1; sy = 1;  end
      DIR_VERT:      begin sx = 0; sy = 1;  end
      default:       begin sx = 1; sy = -1; end
    endcase
    keep = 1'b1;
    for (int s = -1; s <= 1; s += 2) begin
      nr = pr + s * sy;
      nc = pc + s * sx;
      ni = wi + s * sy;
      nj = wj + s * sx;
      if (nr >= 0 && nr < h && nc >= 0 && nc < w && ni >= 0 && ni < 3 && nj >= 0 && nj < 3)
        if (mag_win[ni][nj] > m) keep = 1'b0;
    end
    e.col = COORD_W'(pc);
    e.row = COORD_W'(pr);
    e.mag = keep ? m : '0;
    e.cls = CLASS_NONE;
    if (keep) begin
      if (e.mag >= high_thr) e.cls = CLASS_STRONG;
      else if (e.mag > low_thr) e.cls = CLASS_WEAK;
    end
    e.last = 1'b0;
    pending_edges.push_back(e);
  endfunction

  function automatic void predict_edges(logic signed [GB-1:0] gx, logic signed [GB-1:0] gy);
    int ax, ay, w, h, r, c, before_n;
    longint unsigned lhs;
    logic [MAG_W-1:0] m;
    logic [DIR_W-1:0] d;
    ax = (gx < 0) ? -int'(gx) : int'(gx);
    ay = (gy < 0) ? -int'(gy) : int'(gy);
    m = MAG_W'(root_floor(longint'(ax) * ax + longint'(ay) * ay));
    lhs = longint'(ay) << 16;
    if (lhs < longint'(ax) * TAN_LO) d = DIR_HORZ;
    else if (lhs >= longint'(ax) * TAN_HI) d = DIR_VERT;
    else d = ((gx < 0) == (gy < 0)) ? DIR_DIAG_DOWN : DIR_DIAG_UP;
    w = frame_width();
    h = frame_height();
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    for (int i = 0; i < 3; i++) begin
      mag_win[i][0] = mag_win[i][1]; mag_win[i][1] = mag_win[i][2];
      dir_win[i][0] = dir_win[i][1]; dir_win[i][1] = dir_win[i][2];
    end
    mag_win[0][2] = mag_line[r & 1][c];       dir_win[0][2] = dir_line[r & 1][c];
    mag_win[1][2] = mag_line[(r + 1) & 1][c]; dir_win[1][2] = dir_line[(r + 1) & 1][c];
    mag_win[2][2] = m;                        dir_win[2][2] = d;
    mag_line[r & 1][c] = m;
    dir_line[r & 1][c] = d;
    before_n = pending_edges.size();
    if (r >= 1 && c >= 1) report_pixel(1, 1, r - 1, c - 1, w, h);
    if (r >= 1 && c == w - 1) report_pixel(1, 2, r - 1, c, w, h);
    if (r == h - 1 && c >= 1) report_pixel(2, 1, r, c - 1, w, h);
    if (r == h - 1 && c == w - 1) report_pixel(2, 2, r, c, w, h);
    if (pending_edges.size() > before_n) begin
      pending_edges[$].last = 1'b1;
      last_pred = pending_edges[$];
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic void note_mismatch(string what, edge_pix_t exp_e, edge_pix_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: expected col %0d row %0d mag %0d cls %0d last %0d,",
                " got col %0d row %0d mag %0d cls %0d last %0d"},
               $realtime, what, exp_e.col, exp_e.row, exp_e.mag, exp_e.cls, exp_e.last,
               got.col, got.row, got.mag, got.cls, got.last);
  endfunction

  always @(posedge clk) begin
    edge_pix_t got, exp_e;
    if (!rst) begin
      if (gin.valid && gin.ready) predict_edges(gin.grad_x, gin.grad_y);
      if (eout.valid && eout.ready) begin
        got.col = eout.pixel_col;
        got.row = eout.pixel_row;
        got.mag = eout.thinned_magnitude;
        got.cls = eout.edge_class;
        got.last = eout.last_of_run;
        if (pending_edges.size() == 0) begin
          exp_e = '{default: '0};
          note_mismatch("unexpected result", exp_e, got);
        end else begin
          exp_e = pending_edges.pop_front();
          if (got !== exp_e) note_mismatch("result mismatch", exp_e, got);
        end
      end
      if ((gin.valid && gin.ready) || (eout.valid && eout.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("gradient_non_maximum_suppression test failed");
        $finish;
      end
    end
  end

  // result side: random stalls per result
  initial begin
    int stall;
    eout.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        eout.ready <= 1'b0;
      end
      @(negedge clk);
      eout.ready <= 1'b1;
      do @(posedge clk); while (!eout.valid);
    end
  end

  task automatic send_grad(int gx, int gy);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      gin.valid <= 1'b0;
    end
    @(negedge clk);
    gin.valid <= 1'b1;
    gin.grad_x <= GB'(gx);
    gin.grad_y <= GB'(gy);
    do @(posedge clk); while (!gin.ready);
  endtask

  // block goes idle: all results back, then let the pipeline empty
  task automatic drain();
    @(negedge clk);
    gin.valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DIM_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
  endtask

  function automatic int rand_grad();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return $signed(11'($urandom));
    if (k < 8) return $urandom_range(0, 80) - 40;
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1023;
      2: return -1024;
      default: return $urandom_range(0, 1) ? 1 : -1;
    endcase
  endfunction

  function automatic int rand_thr();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 2047;
      2: return $urandom_range(0, 2047);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  dir_row_t dir_rows[17] = '{
    '{0, 0, 200, 80, 1, 11'd0, CLASS_NONE},
    '{1023, 0, 200, 80, 1, 11'd1023, CLASS_STRONG},
    '{-1024, 0, 200, 80, 1, 11'd1024, CLASS_STRONG},
    '{0, -1024, 200, 80, 1, 11'd1024, CLASS_STRONG},
    '{-1024, -1024, 200, 80, 1, 11'd1448, CLASS_STRONG},
    '{1023, 1023, 200, 80, 1, 11'd1446, CLASS_STRONG},
    '{80, 0, 200, 80, 1, 11'd80, CLASS_NONE},
    '{81, 0, 200, 80, 1, 11'd81, CLASS_WEAK},
    '{0, 199, 200, 80, 1, 11'd199, CLASS_WEAK},
    '{0, 200, 200, 80, 1, 11'd200, CLASS_STRONG},
    '{3, 4, 200, 80, 1, 11'd5, CLASS_NONE},
    '{-1, 1, 200, 80, 1, 11'd1, CLASS_NONE},
    '{-37, 90, 200, 80, 0, 11'd0, CLASS_NONE},
    '{50, 0, 50, 2047, 1, 11'd50, CLASS_STRONG},
    '{0, -49, 50, 2047, 1, 11'd49, CLASS_NONE},
    '{0, 0, 0, 0, 1, 11'd0, CLASS_STRONG},
    '{-1024, -1024, 2047, 2047, 1, 11'd1448, CLASS_NONE}
  };

  initial begin
    int sent, kind, w, h, n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    gin.valid = 1'b0;
    gin.grad_x = '0;
    gin.grad_y = '0;
    no_idle = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    width_reg = RST_IMAGE_WIDTH;
    height_reg = RST_IMAGE_HEIGHT;
    high_thr = RST_HIGH_THRESHOLD;
    low_thr = RST_LOW_THRESHOLD;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        mag_win[i][j] = '0;
        dir_win[i][j] = DIR_HORZ;
      end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 1x1 frame through the zero-size rule: every pixel reports itself, no neighbours
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].hi != high_thr || dir_rows[i].lo != low_thr) begin
        write_reg(REG_HIGH_THRESHOLD, dir_rows[i].hi);
        write_reg(REG_LOW_THRESHOLD, dir_rows[i].lo);
      end
      send_grad(dir_rows[i].gx, dir_rows[i].gy);
      drain();
      if (dir_rows[i].typed &&
          (last_pred.mag !== dir_rows[i].mag || last_pred.cls !== dir_rows[i].cls)) begin
        mismatches++;
        $display("row %0d: predicted mag %0d cls %0d, table mag %0d cls %0d",
                 i, last_pred.mag, last_pred.cls, dir_rows[i].mag, dir_rows[i].cls);
      end
    end

    sent = 0;
    while (sent < RANDOM_N) begin
      kind = $urandom_range(0, 11);
      no_idle = ($urandom_range(0, 4) == 0);
      if (kind == 0) begin
        // width at or above the limit, partial first line(s)
        w = $urandom_range(0, 1) ? 4095 : 2048;
        h = $urandom_range(1, 2);
        n = $urandom_range(8, 16);
      end else if (kind == 1) begin
        // oversized height, a few short lines
        w = $urandom_range(1, 4);
        h = 4095;
        n = $urandom_range(10, 20);
      end else begin
        w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(1, 2);
      end
      drain();
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_HIGH_THRESHOLD, rand_thr());
      write_reg(REG_LOW_THRESHOLD, rand_thr());
      repeat (n) send_grad(rand_grad(), rand_grad());
      sent += n;
    end

    drain();
    if (mismatches == 0) begin
      $display("gradient_non_maximum_suppression test passed");
    end else begin
      $display("gradient_non_maximum_suppression test failed");
    end
    $finish;
  end

endmodule

### files.f
sv/gnms_pkg.sv
sv/gnms_if.sv
sv/gnms_sqrt.sv
sv/gnms_window.sv
sv/gnms_emit.sv
sv/gradient_non_maximum_suppression.sv
verif/testbench.sv
